// ===== design/mcpg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared types and constants of the midpoint circle point generator: command
// codes, the job record that links the front end to the back end, and the
// octant tables.
// ----------------------------------------------------------------------------
package mcpg_pkg;

    // Command codes of an input transaction.
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } command_t;

    // Field widths.
    localparam int CoordW  = 16;
    localparam int ColorW  = 16;
    localparam int RadiusW = 8;
    localparam int StepAW  = 9;
    localparam int StepBW  = 10;
    localparam int ErrW    = 12;

    // Constants of the decision error recurrence.
    localparam logic signed [ErrW-1:0] ErrStartBase = 12'sd3;
    localparam logic signed [ErrW-1:0] ErrStepNeg   = 12'sd6;
    localparam logic signed [ErrW-1:0] ErrStepPos   = 12'sd10;

    // Default number of queued jobs between the front and the back end.
    localparam int QueueDepthDefault = 2;

    // Octant tables, one bit per point in emission order (bit 0 first).
    // XIsB: the x offset uses b and the y offset uses a.
    localparam logic [7:0] XIsB = 8'b1010_0110;
    localparam logic [7:0] XNeg = 8'b1111_0000;
    localparam logic [7:0] YNeg = 8'b1100_0011;

    // One step of work: the pair (a, b) to emit and the circle it belongs to.
    typedef struct packed {
        logic [CoordW-1:0]        center_x;
        logic [CoordW-1:0]        center_y;
        logic [ColorW-1:0]        color;
        logic [StepAW-1:0]        step_a;
        logic signed [StepBW-1:0] step_b;
        logic                     done;
    } job_t;

    // Status of the job queue as seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== design/midpoint_circle_point_generator.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator
// Midpoint circle rasterizer: start and advance commands in, circle points
// out, eight per drawing step.
// ----------------------------------------------------------------------------
// A start transaction latches center, radius and color and produces no
// points. Each accepted advance transaction makes the front end step the
// midpoint recurrence and, while the circle is in progress, queue one job
// of eight points (up to QueueDepth jobs wait). The back end emits one
// point per cycle through a registered output while out_stall is low; the
// job of a step passes through the queue, the back end's job register and
// the output register before its first point appears. Starts and idle
// advances are accepted whenever the queue has room.
module midpoint_circle_point_generator
#(
    parameter int QueueDepth = mcpg_pkg::QueueDepthDefault
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [mcpg_pkg::CoordW-1:0]   center_x,
    input  logic [mcpg_pkg::CoordW-1:0]   center_y,
    input  logic [mcpg_pkg::RadiusW-1:0]  radius,
    input  logic [mcpg_pkg::ColorW-1:0]   pen_color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mcpg_pkg::CoordW-1:0]   point_x,
    output logic [mcpg_pkg::CoordW-1:0]   point_y,
    output logic [mcpg_pkg::ColorW-1:0]   point_color,
    output logic                          last_of_step,
    output logic                          circle_done
);

    mcpg_pkg::queue_status_t  queue_status;
    mcpg_pkg::job_t           push_job;
    mcpg_pkg::job_t           pop_job;
    logic                     push;
    logic                     pop;

    mcpg_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .pen_color    (pen_color),
        .queue_status (queue_status),
        .push         (push),
        .push_job     (push_job)
    );

    mcpg_queue #(.Depth(QueueDepth)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (queue_status)
    );

    mcpg_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .pop_job      (pop_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_color  (point_color),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

// ===== design/mcpg_front.sv =====
// ----------------------------------------------------------------------------
// mcpg_front
// Front end: accepts commands, keeps the running midpoint state of the
// current circle and hands every emitting step to the job queue.
// ----------------------------------------------------------------------------
module mcpg_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [mcpg_pkg::CoordW-1:0]       center_x,
    input  logic [mcpg_pkg::CoordW-1:0]       center_y,
    input  logic [mcpg_pkg::RadiusW-1:0]      radius,
    input  logic [mcpg_pkg::ColorW-1:0]       pen_color,
    input  mcpg_pkg::queue_status_t           queue_status,
    output logic                              push,
    output mcpg_pkg::job_t                    push_job
);

    logic [mcpg_pkg::CoordW-1:0]         center_x_reg, center_x_next;
    logic [mcpg_pkg::CoordW-1:0]         center_y_reg, center_y_next;
    logic [mcpg_pkg::ColorW-1:0]         color_reg, color_next;
    logic [mcpg_pkg::StepAW-1:0]         a_reg, a_next;
    logic signed [mcpg_pkg::StepBW-1:0]  b_reg, b_next;
    logic signed [mcpg_pkg::ErrW-1:0]    err_reg, err_next;
    logic                                active_reg, active_next;

    logic                                accept;
    logic                                emit;
    logic [mcpg_pkg::StepAW-1:0]         a_inc;
    logic signed [mcpg_pkg::ErrW-1:0]    a_inc_ext;
    logic signed [mcpg_pkg::ErrW-1:0]    b_ext;
    logic signed [mcpg_pkg::StepBW-1:0]  b_step;
    logic                                step_done;

    // The front end only waits when the queue has no room.
    assign in_stall = queue_status.full;
    assign accept   = in_valid && !in_stall;

    // A step is drawn only while a circle is in progress and a <= b.
    assign emit = accept && (command == mcpg_pkg::CMD_ADVANCE) && active_reg
                  && ($signed({1'b0, a_reg}) <= b_reg);

    // Next pair of the midpoint scheme.
    assign a_inc     = a_reg + 1'b1;
    assign a_inc_ext = $signed({{(mcpg_pkg::ErrW-mcpg_pkg::StepAW){1'b0}}, a_inc});
    assign b_ext     = $signed({{(mcpg_pkg::ErrW-mcpg_pkg::StepBW){b_reg[mcpg_pkg::StepBW-1]}},
                                b_reg});
    assign b_step    = err_reg[mcpg_pkg::ErrW-1] ? b_reg
                                                 : (b_reg - mcpg_pkg::StepBW'(1));
    assign step_done = $signed({1'b0, a_inc}) > b_step;

    // State update for start and advance commands.
    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        color_next    = color_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        err_next      = err_reg;
        active_next   = active_reg;
        if (accept && (command == mcpg_pkg::CMD_START))
        begin
            center_x_next = center_x;
            center_y_next = center_y;
            color_next    = pen_color;
            a_next        = '0;
            b_next        = $signed({{(mcpg_pkg::StepBW-mcpg_pkg::RadiusW){1'b0}}, radius});
            err_next      = mcpg_pkg::ErrStartBase
                            - $signed({{(mcpg_pkg::ErrW-mcpg_pkg::RadiusW-1){1'b0}},
                                       radius, 1'b0});
            active_next   = 1'b1;
        end
        else if (emit)
        begin
            a_next = a_inc;
            b_next = b_step;
            if (err_reg[mcpg_pkg::ErrW-1])
            begin
                err_next = err_reg + (a_inc_ext <<< 2) + mcpg_pkg::ErrStepNeg;
            end
            else
            begin
                err_next = err_reg + mcpg_pkg::ErrStepPos + ((a_inc_ext - b_ext) <<< 2);
            end
            if (step_done)
            begin
                active_next = 1'b0;
            end
        end
    end

    // Job for the back end: the pair before the step, with the circle's data.
    always_comb
    begin
        push              = emit;
        push_job.center_x = center_x_reg;
        push_job.center_y = center_y_reg;
        push_job.color    = color_reg;
        push_job.step_a   = a_reg;
        push_job.step_b   = b_reg;
        push_job.done     = step_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            color_reg    <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            err_reg      <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            color_reg    <= color_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            err_reg      <= err_next;
            active_reg   <= active_next;
        end
    end

endmodule

// ===== design/mcpg_queue.sv =====
// ----------------------------------------------------------------------------
// mcpg_queue
// Short first-in first-out queue of step jobs between the front and the
// back end.
// ----------------------------------------------------------------------------
module mcpg_queue
#(
    parameter int Depth = mcpg_pkg::QueueDepthDefault
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mcpg_pkg::job_t           push_job,
    input  logic                     pop,
    output mcpg_pkg::job_t           pop_job,
    output mcpg_pkg::queue_status_t  status
);

    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    mcpg_pkg::job_t      mem [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == CountW'(Depth));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/mcpg_back.sv =====
// ----------------------------------------------------------------------------
// mcpg_back
// Back end: takes one step job at a time and emits its eight symmetric
// points, one per cycle while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module mcpg_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcpg_pkg::queue_status_t       queue_status,
    input  mcpg_pkg::job_t                pop_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mcpg_pkg::CoordW-1:0]   point_x,
    output logic [mcpg_pkg::CoordW-1:0]   point_y,
    output logic [mcpg_pkg::ColorW-1:0]   point_color,
    output logic                          last_of_step,
    output logic                          circle_done
);

    mcpg_pkg::job_t                 job_reg, job_next;
    logic                           busy_reg, busy_next;
    logic [2:0]                     idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [mcpg_pkg::CoordW-1:0]    x_reg, x_next;
    logic [mcpg_pkg::CoordW-1:0]    y_reg, y_next;
    logic [mcpg_pkg::ColorW-1:0]    color_reg, color_next;
    logic                           last_reg, last_next;
    logic                           done_reg, done_next;

    logic                           slot_free;
    logic                           gen;
    logic                           last_point;
    logic [mcpg_pkg::CoordW-1:0]    a_ext;
    logic [mcpg_pkg::CoordW-1:0]    b_ext;
    logic [mcpg_pkg::CoordW-1:0]    dx;
    logic [mcpg_pkg::CoordW-1:0]    dy;

    // The output register can take a new point when empty or being drained.
    assign slot_free  = !out_valid_reg || !out_stall;
    assign gen        = busy_reg && slot_free;
    assign last_point = (idx_reg == 3'd7);
    assign pop        = !queue_status.empty && (!busy_reg || (gen && last_point));

    // Offsets of the current point, chosen by the octant tables.
    assign a_ext = {{(mcpg_pkg::CoordW-mcpg_pkg::StepAW){1'b0}}, job_reg.step_a};
    assign b_ext = {{(mcpg_pkg::CoordW-mcpg_pkg::StepBW){job_reg.step_b[mcpg_pkg::StepBW-1]}},
                    job_reg.step_b};
    assign dx    = mcpg_pkg::XIsB[idx_reg] ? b_ext : a_ext;
    assign dy    = mcpg_pkg::XIsB[idx_reg] ? a_ext : b_ext;

    // Job sequencing and point generation.
    always_comb
    begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        color_next     = color_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
        if (gen)
        begin
            out_valid_next = 1'b1;
            x_next         = mcpg_pkg::XNeg[idx_reg] ? (job_reg.center_x - dx)
                                                     : (job_reg.center_x + dx);
            y_next         = mcpg_pkg::YNeg[idx_reg] ? (job_reg.center_y - dy)
                                                     : (job_reg.center_y + dy);
            color_next     = job_reg.color;
            last_next      = last_point;
            done_next      = last_point && job_reg.done;
            idx_next       = idx_reg + 1'b1;
            if (last_point)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            job_next  = pop_job;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        color_reg <= color_next;
        last_reg  <= last_next;
        done_reg  <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = x_reg;
    assign point_y      = y_reg;
    assign point_color  = color_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

    // The end of a circle is always flagged on the last point of a step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg)
        else $error("circle_done without last_of_step");

    // An idle sequencer always restarts at the first octant.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> idx_reg == 3'd0)
        else $error("point index not cleared while idle");

    // A point that is not the last of its step leaves its job in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> busy_reg)
        else $error("step job dropped before its eighth point");

endmodule
